// File: rtl/core/pjt_pkg.sv
// Shared types, codes and constants for the priority job table.
package pjt_pkg;

    localparam int QueueDepthDef = 4;
    localparam int ActW          = 3;
    localparam int IdW           = 16;
    localparam int KindW         = 2;
    localparam int UrgW          = 8;
    localparam int WantW         = 3;
    localparam int StatW         = 2;
    localparam int OccW          = 3;
    localparam int ListMax       = 4;

    // Sentinel above any stored urgency, seeds the minimum search
    localparam logic [UrgW:0] NoUrgency = (UrgW + 1)'(257);

    typedef enum logic [ActW-1:0] {
        ACT_SUBMIT   = 3'd0,
        ACT_DISPATCH = 3'd1,
        ACT_CLEAR    = 3'd2,
        ACT_REMOVE   = 3'd3,
        ACT_REPRIO   = 3'd4,
        ACT_COUNT    = 3'd5,
        ACT_LIST     = 3'd6
    } action_t;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [KindW-1:0] kind;
        logic [UrgW-1:0]  urg;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    typedef struct packed {
        logic           clear;
        logic           beat;
        logic           by_id;
        logic [IdW-1:0] target;
    } scan_ctl_t;

endpackage

// File: rtl/core/pjt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pjt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/pjt_scan.sv
// Shared compare unit: running minimum-urgency or first-id-match search.
module pjt_scan import pjt_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepthDef,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  scan_ctl_t     ctl,
    input  logic [AW-1:0] idx,
    input  entry_t        rd_entry,
    output logic          found,
    output logic [AW-1:0] pos,
    output entry_t        sel
);

    logic            found_reg;
    logic [UrgW:0]   best_reg;
    logic [AW-1:0]   pos_reg;
    entry_t          sel_reg;
    logic            take;

    // Strictly lower urgency keeps the oldest on a tie; id match keeps the first
    always_comb
    begin
        if (ctl.by_id)
        begin
            take = !found_reg && (rd_entry.id == ctl.target);
        end
        else
        begin
            take = ({1'b0, rd_entry.urg} < best_reg);
        end
    end

    // Track whether anything was picked and the best urgency so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= NoUrgency;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
            best_reg  <= NoUrgency;
        end
        else if (ctl.beat && take)
        begin
            found_reg <= 1'b1;
            best_reg  <= {1'b0, rd_entry.urg};
        end
    end

    // Hold the picked entry and its slot
    always_ff @(posedge clk)
    begin
        if (ctl.beat && take)
        begin
            pos_reg <= idx;
            sel_reg <= rd_entry;
        end
    end

    assign found = found_reg;
    assign pos   = pos_reg;
    assign sel   = sel_reg;

endmodule

// File: rtl/core/priority_job_table.sv
// Top level of the priority job table: sequencer, counters and result register.
// Submit, clear, count, unused codes and early rejects: result in the cycle after start.
// Dispatch/remove: search the held entries, shift the later ones down, then the result.
// Reprioritize and a remove miss: search, then the result. List of n entries: n beats.
// busy is high while a search, shift or list runs; the receiver cannot stall results.
// rst_n clears the table count, the id counter and the sequencer; the RAM is not cleared.
module priority_job_table import pjt_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepthDef
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ActW-1:0]  action,
    input  logic [IdW-1:0]   target_id,
    input  logic [KindW-1:0] kind,
    input  logic [UrgW-1:0]  urgency,
    input  logic [WantW-1:0] want_count,
    output logic             out_valid,
    output logic [StatW-1:0] status,
    output logic [IdW-1:0]   out_id,
    output logic [KindW-1:0] out_kind,
    output logic [UrgW-1:0]  out_urgency,
    output logic [OccW-1:0]  occupancy,
    output logic             last
);

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CmpW = (CW > WantW) ? CW : WantW;

    state_t           state_reg, state_next;
    action_t          act_reg, act_in;
    logic [IdW-1:0]   tid_reg;
    logic [UrgW-1:0]  urg_reg;
    logic [CW-1:0]    held_reg, held_next;
    logic [IdW-1:0]   idc_reg, idc_next;
    logic [CW-1:0]    limit_reg, limit_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;

    logic             accept;
    logic             issue;
    logic [WantW-1:0] want_cap;
    logic [CW-1:0]    list_n;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EntryW-1:0] ram_rdata;
    entry_t           rd_entry;

    scan_ctl_t        scan_ctl;
    logic             scan_found;
    logic [AW-1:0]    scan_pos;
    entry_t           scan_sel;

    logic             em_valid;
    status_t          em_status;
    logic [IdW-1:0]   em_id;
    logic [KindW-1:0] em_kind;
    logic [UrgW-1:0]  em_urg;
    logic [CW-1:0]    em_occ;
    logic             em_last;

    logic             ov_reg;
    status_t          status_reg;
    logic [IdW-1:0]   oid_reg;
    logic [KindW-1:0] okind_reg;
    logic [UrgW-1:0]  ourg_reg;
    logic [OccW-1:0]  occ_reg;
    logic             last_reg;

    assign act_in   = action_t'(action);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign issue    = (rd_idx_reg != limit_reg);
    assign rd_entry = entry_t'(ram_rdata);

    // Cap the list length at the list limit and at the entries held
    always_comb
    begin
        want_cap = (want_count > WantW'(ListMax)) ? WantW'(ListMax) : want_count;
        if (CmpW'(held_reg) < CmpW'(want_cap))
        begin
            list_n = held_reg;
        end
        else
        begin
            list_n = CW'(want_cap);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (act_in) inside
                        ACT_DISPATCH, ACT_REMOVE, ACT_REPRIO:
                        begin
                            if (held_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_LIST:
                        begin
                            if (list_n != '0)
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (scan_found && (act_reg != ACT_REPRIO))
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT, S_LIST:
            begin
                if (!issue)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control, RAM access and result beats
    always_comb
    begin
        held_next     = held_reg;
        idc_next      = idc_reg;
        limit_next    = limit_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = rd_idx_reg[AW-1:0];

        scan_ctl.clear  = accept;
        scan_ctl.beat   = 1'b0;
        scan_ctl.by_id  = (act_reg != ACT_DISPATCH);
        scan_ctl.target = tid_reg;

        em_valid  = 1'b0;
        em_status = ST_OK;
        em_id     = '0;
        em_kind   = '0;
        em_urg    = '0;
        em_occ    = held_reg;
        em_last   = 1'b1;

        // Issue one read per cycle while entries remain
        if ((state_reg == S_SCAN || state_reg == S_SHIFT || state_reg == S_LIST) && issue)
        begin
            rd_idx_next   = rd_idx_reg + CW'(1);
            pend_next     = 1'b1;
            pend_idx_next = rd_idx_reg[AW-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (act_in) inside
                        ACT_SUBMIT:
                        begin
                            em_valid = 1'b1;
                            if (held_reg == CW'(QUEUE_DEPTH))
                            begin
                                em_status = ST_FULL;
                            end
                            else
                            begin
                                idc_next  = idc_reg + IdW'(1);
                                held_next = held_reg + CW'(1);
                                ram_we    = 1'b1;
                                ram_waddr = held_reg[AW-1:0];
                                ram_wdata = '{id: idc_next, kind: kind, urg: urgency};
                                em_id     = idc_next;
                                em_kind   = kind;
                                em_urg    = urgency;
                                em_occ    = held_next;
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            if (held_reg == '0)
                            begin
                                em_valid  = 1'b1;
                                em_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                limit_next  = held_reg;
                            end
                        end
                        ACT_REMOVE, ACT_REPRIO:
                        begin
                            if (held_reg == '0)
                            begin
                                em_valid  = 1'b1;
                                em_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                limit_next  = held_reg;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            held_next = '0;
                            em_valid  = 1'b1;
                            em_occ    = '0;
                        end
                        ACT_LIST:
                        begin
                            if (list_n == '0)
                            begin
                                em_valid  = 1'b1;
                                em_status = (held_reg == '0) ? ST_EMPTY : ST_OK;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                limit_next  = list_n;
                            end
                        end
                        default:
                        begin
                            em_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                scan_ctl.beat = pend_reg;
            end
            S_PICK:
            begin
                if (!scan_found)
                begin
                    em_valid  = 1'b1;
                    em_status = ST_NOT_FOUND;
                end
                else if (act_reg == ACT_REPRIO)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_pos;
                    ram_wdata = '{id: scan_sel.id, kind: scan_sel.kind, urg: urg_reg};
                    em_valid  = 1'b1;
                    em_id     = tid_reg;
                    em_kind   = scan_sel.kind;
                    em_urg    = urg_reg;
                end
                else
                begin
                    rd_idx_next = CW'(scan_pos) + CW'(1);
                end
            end
            S_SHIFT:
            begin
                // Move each later entry down by one slot
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - AW'(1);
                    ram_wdata = rd_entry;
                end
                if (!issue)
                begin
                    held_next = held_reg - CW'(1);
                    em_valid  = 1'b1;
                    em_id     = scan_sel.id;
                    em_kind   = scan_sel.kind;
                    em_urg    = scan_sel.urg;
                    em_occ    = held_next;
                end
            end
            S_LIST:
            begin
                if (pend_reg)
                begin
                    em_valid = 1'b1;
                    em_id    = rd_entry.id;
                    em_kind  = rd_entry.kind;
                    em_urg   = rd_entry.urg;
                    em_last  = ((CW'(pend_idx_reg) + CW'(1)) == limit_reg);
                end
            end
            default:
            begin
                em_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            idc_reg      <= '0;
            limit_reg    <= '0;
            rd_idx_reg   <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            act_reg      <= ACT_SUBMIT;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            idc_reg      <= idc_next;
            limit_reg    <= limit_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            ov_reg       <= em_valid;
            if (accept)
            begin
                act_reg <= act_in;
            end
        end
    end

    // Hold the command operands and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tid_reg <= target_id;
            urg_reg <= urgency;
        end
        if (em_valid)
        begin
            status_reg <= em_status;
            oid_reg    <= em_id;
            okind_reg  <= em_kind;
            ourg_reg   <= em_urg;
            occ_reg    <= OccW'(em_occ);
            last_reg   <= em_last;
        end
    end

    pjt_ram #(
        .WIDTH (EntryW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pjt_scan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .idx      (pend_idx_reg),
        .rd_entry (rd_entry),
        .found    (scan_found),
        .pos      (scan_pos),
        .sel      (scan_sel)
    );

    assign out_valid   = ov_reg;
    assign status      = status_reg;
    assign out_id      = oid_reg;
    assign out_kind    = okind_reg;
    assign out_urgency = ourg_reg;
    assign occupancy   = occ_reg;
    assign last        = last_reg;

endmodule

// File: rtl/core/pjt_checker.sv
// Port-level checks on the job table's result beats, bound to the top level.
module pjt_checker import pjt_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepthDef
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             out_valid,
    input logic [StatW-1:0] status,
    input logic [OccW-1:0]  occupancy,
    input logic             last
);

    // A beat only follows a command start or a running command
    a_beat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($past(busy) || $past(start)))
        else $error("result beat without a command");

    // Full is only reported when every slot is taken
    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == OccW'(QUEUE_DEPTH)))
        else $error("full status with free slots");

    // Empty is only reported on an empty table
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with entries held");

    // The final beat of a command leaves the block free
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> !busy)
        else $error("busy after final beat");

    // List beats come back to back until the final one
    a_list_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |=> out_valid)
        else $error("gap inside a multi-beat result");

endmodule

bind priority_job_table pjt_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
